@@ rtl/core/lcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcf_pkg;

    // Commands carried by an input request. The unused code is ignored.
    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_SET_BRIGHT = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_e;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MODE = 2'd1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [7:0] STEP_SIZE_RESET = 8'd1;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] channel;
        logic [7:0] level;
    } in_item_t;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] brightness;
        logic       moved;
        logic       any_moved;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] step_size;
        logic       fade_mode;
    } fade_cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/lcf_chan_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One write port, one read port with registered read data. Each entry has a
// valid bit cleared by reset; an entry never written since reset reads zero.
module lcf_chan_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

    // A read and a write of the same entry in one cycle would return stale data.
    a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same entry in one cycle");

endmodule

`default_nettype wire

@@ rtl/core/lcf_fade.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Computes the next brightness of one channel from its brightness and target.
module lcf_fade (
    input  wire lcf_pkg::fade_cfg_t cfg,
    input  wire logic [7:0]         cur,
    input  wire logic [7:0]         target,
    output logic      [7:0]         next_level,
    output logic                    moved
);

    logic [8:0] tgt_plus_step;
    logic [8:0] cur_plus_step;
    logic [7:0] normal_level;
    logic [7:0] doubled;
    logic [7:0] flashy_level;

    always_comb
    begin
        tgt_plus_step = {1'b0, target} + {1'b0, cfg.step_size};
        cur_plus_step = {1'b0, cur} + {1'b0, cfg.step_size};

        if (cur > target)
        begin
            if ({1'b0, cur} > tgt_plus_step)
            begin
                normal_level = cur - cfg.step_size;
            end
            else
            begin
                normal_level = cur - 8'd1;
            end
        end
        else
        begin
            if (cur_plus_step < {1'b0, target})
            begin
                normal_level = cur_plus_step[7:0];
            end
            else
            begin
                normal_level = cur + 8'd1;
            end
        end

        // Doubling may wrap below the target, in which case it snaps to it.
        doubled = (cur > target) ? {cur[6:0], 1'b0} : cur;
        flashy_level = (doubled < target) ? target : doubled;

        if (cur == target)
        begin
            next_level = cur;
        end
        else if (cfg.fade_mode)
        begin
            next_level = flashy_level;
        end
        else
        begin
            next_level = normal_level;
        end

        moved = (next_level != cur);
    end

endmodule

`default_nettype wire

@@ rtl/core/led_channel_fader.sv @@
// A set-target or set-brightness request is taken while the block is idle and gives no result.
// A tick reads each channel through the registered memory outputs into the result register,
// giving one result per cycle while the output is taken; one channel is read per cycle from
// the brightness and target memories. No request is taken until the last channel is stepped.
// Reset clears both memories to zero through per-entry valid bits, sets step_size to 1
// and fade_mode to 0; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module led_channel_fader #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire lcf_pkg::in_item_t                   item,

    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output lcf_pkg::out_item_t                       result,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Index width for the channel memories; at least one bit.
    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    // Control and configuration registers.
    lcf_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               any_reg, any_next;
    logic               out_valid_reg, out_valid_next;
    lcf_pkg::out_item_t out_data_reg, out_data_next;
    lcf_pkg::fade_cfg_t cfg_reg;

    // Handshake and datapath signals.
    logic               item_accept;
    logic               tick_accept;
    logic               set_target;
    logic               set_bright;
    logic               chan_in_range;
    logic [IDX_W-1:0]   set_addr;
    logic [IDX_W+2:0]   set_addr_wide;
    logic [IDX_W+2:0]   out_chan_wide;
    logic               advance;
    logic               idx_last;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               bright_wr_en;
    logic [IDX_W-1:0]   bright_wr_addr;
    logic [7:0]         bright_wr_data;
    logic [7:0]         cur_bright;
    logic [7:0]         cur_target;
    logic [7:0]         new_bright;
    logic               chan_moved;

    // The item channel is three bits; the channel count may be smaller or larger.
    assign item_accept   = item_valid && item_ready;
    assign chan_in_range = (32'(item.channel) < NUM_CHANNELS);
    assign set_addr_wide = {{IDX_W{1'b0}}, item.channel};
    assign set_addr      = set_addr_wide[IDX_W-1:0];
    assign tick_accept   = item_accept && (item.cmd == lcf_pkg::CMD_TICK);
    assign set_target    = item_accept && chan_in_range && (item.cmd == lcf_pkg::CMD_SET_TARGET);
    assign set_bright    = item_accept && chan_in_range && (item.cmd == lcf_pkg::CMD_SET_BRIGHT);

    // In the run state the memory outputs hold the channel at idx_reg. It is
    // written back and presented as a result once the output register is free.
    assign idx_last = (idx_reg == LAST_IDX);
    assign advance  = (state_reg == lcf_pkg::ST_RUN) && (!out_valid_reg || result_ready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcf_pkg::ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = lcf_pkg::ST_RUN;
                end
            end
            lcf_pkg::ST_RUN:
            begin
                if (advance && idx_last)
                begin
                    state_next = lcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: request acceptance and the read of the next channel. The
    // read of channel i+1 overlaps the write-back of channel i, so the two
    // never address the same entry.
    always_comb
    begin
        item_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg + IDX_W'(1);
        case (state_reg)
            lcf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                rd_en      = tick_accept;
                rd_addr    = '0;
            end
            lcf_pkg::ST_RUN:
            begin
                rd_en = advance && !idx_last;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Channel pointer and the running any-changed flag.
    always_comb
    begin
        idx_next = idx_reg;
        any_next = any_reg;
        if (tick_accept)
        begin
            idx_next = '0;
            any_next = 1'b0;
        end
        else if (advance)
        begin
            any_next = any_reg | chan_moved;
            if (!idx_last)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Result register: filled on each step and emptied when taken.
    assign out_chan_wide = {3'b000, idx_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_channel = out_chan_wide[2:0];
            out_data_next.brightness  = new_bright;
            out_data_next.moved       = chan_moved;
            out_data_next.last        = idx_last;
            out_data_next.any_moved   = idx_last && (any_reg || chan_moved);
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The brightness memory is written by a set request or by the tick write-back.
    always_comb
    begin
        if (advance)
        begin
            bright_wr_en   = 1'b1;
            bright_wr_addr = idx_reg;
            bright_wr_data = new_bright;
        end
        else
        begin
            bright_wr_en   = set_bright;
            bright_wr_addr = set_addr;
            bright_wr_data = item.level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcf_pkg::ST_IDLE;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= lcf_pkg::STEP_SIZE_RESET;
            cfg_reg.fade_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcf_pkg::CFG_STEP_SIZE:
                begin
                    cfg_reg.step_size <= cfg_data[7:0];
                end
                lcf_pkg::CFG_FADE_MODE:
                begin
                    cfg_reg.fade_mode <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    lcf_chan_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (IDX_W)
    ) u_bright_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bright_wr_en),
        .wr_addr (bright_wr_addr),
        .wr_data (bright_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cur_bright)
    );

    lcf_chan_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (IDX_W)
    ) u_target_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (set_target),
        .wr_addr (set_addr),
        .wr_data (item.level),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cur_target)
    );

    lcf_fade u_fade (
        .cfg        (cfg_reg),
        .cur        (cur_bright),
        .target     (cur_target),
        .next_level (new_bright),
        .moved      (chan_moved)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // A tick always starts its sweep at channel zero.
    a_tick_starts_at_zero : assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> (state_reg == lcf_pkg::ST_RUN) && (idx_reg == '0))
        else $error("tick did not start at channel zero");

    // The sweep ends right after the last channel is written back.
    a_sweep_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_last) |=> (state_reg == lcf_pkg::ST_IDLE))
        else $error("sweep did not end after the last channel");

    // The any-changed flag shows only on the final result of a tick.
    a_any_only_on_last : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> !result.any_moved)
        else $error("any_moved set on a result that is not last");

    // A step never overwrites a result that has not been taken.
    a_no_result_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int NCH = 8;

    // Generous bound on the run length, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Cycles allowed after the last result before a register write or the
    // end of the run; this covers any request still being taken by the block.
    localparam int SETTLE_CYCLES = NCH + 4;

    // Scoreboard: it keeps its own copy of the per-channel brightness and
    // target, plus the fade registers, and a queue of the channel reports
    // that the block still owes.
    class fade_scoreboard;
        logic [7:0] level_now [NCH];
        logic [7:0] level_goal [NCH];
        logic [7:0] step;
        logic       flashy;
        lcf_pkg::out_item_t owed_reports [$];
        int unsigned fail_count;

        function new();
            for (int i = 0; i < NCH; i++)
            begin
                level_now[i]  = 8'd0;
                level_goal[i] = 8'd0;
            end
            step       = lcf_pkg::STEP_SIZE_RESET;
            flashy     = 1'b0;
            fail_count = 0;
        endfunction

        function void write_register(logic [lcf_pkg::CFG_IDX_W-1:0] idx,
                                     logic [lcf_pkg::CFG_DATA_W-1:0] data);
            if (idx == lcf_pkg::CFG_STEP_SIZE)
                step = data;
            else if (idx == lcf_pkg::CFG_FADE_MODE)
                flashy = data[0];
        endfunction

        // One fade step of a channel whose brightness differs from its target.
        function logic [7:0] faded_level(logic [7:0] b, logic [7:0] t);
            logic [8:0] wide_b;
            logic [8:0] wide_t;
            logic [7:0] nb;
            wide_b = {1'b0, b};
            wide_t = {1'b0, t};
            nb     = b;
            if (flashy)
            begin
                if (b > t)
                    nb = {b[6:0], 1'b0};
                if (nb < t)
                    nb = t;
            end
            else if (b > t)
            begin
                if (wide_b > wide_t + {1'b0, step})
                    nb = b - step;
                else
                    nb = b - 8'd1;
            end
            else
            begin
                if (wide_b + {1'b0, step} < wide_t)
                    nb = b + step;
                else
                    nb = b + 8'd1;
            end
            return nb;
        endfunction

        // Called once per accepted input request.
        function void note_request(lcf_pkg::in_item_t req);
            logic      any;
            logic [7:0] nb;
            lcf_pkg::out_item_t rep;
            any = 1'b0;
            case (req.cmd)
                lcf_pkg::CMD_SET_TARGET:
                begin
                    if (int'(req.channel) < NCH)
                        level_goal[req.channel] = req.level;
                end
                lcf_pkg::CMD_SET_BRIGHT:
                begin
                    if (int'(req.channel) < NCH)
                        level_now[req.channel] = req.level;
                end
                lcf_pkg::CMD_TICK:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        nb = level_now[i];
                        if (level_now[i] != level_goal[i])
                            nb = faded_level(level_now[i], level_goal[i]);
                        rep.out_channel = 3'(i);
                        rep.brightness  = nb;
                        rep.moved       = (nb != level_now[i]);
                        any             = any | rep.moved;
                        rep.last        = (i == NCH - 1);
                        rep.any_moved   = rep.last ? any : 1'b0;
                        level_now[i]    = nb;
                        owed_reports.push_back(rep);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Called once per accepted channel report.
        function void check_result(lcf_pkg::out_item_t got);
            lcf_pkg::out_item_t want;
            if (owed_reports.size() == 0)
            begin
                $display("%0t: unexpected report ch=%0d bright=%0d moved=%0b any=%0b last=%0b",
                         $time, got.out_channel, got.brightness, got.moved,
                         got.any_moved, got.last);
                fail_count++;
                return;
            end
            want = owed_reports.pop_front();
            if (got.out_channel !== want.out_channel)
            begin
                $display("%0t: out_channel expected %0d actual %0d",
                         $time, want.out_channel, got.out_channel);
                fail_count++;
            end
            if (got.brightness !== want.brightness)
            begin
                $display("%0t: ch %0d brightness expected %0d actual %0d",
                         $time, want.out_channel, want.brightness, got.brightness);
                fail_count++;
            end
            if (got.moved !== want.moved)
            begin
                $display("%0t: ch %0d moved expected %0b actual %0b",
                         $time, want.out_channel, want.moved, got.moved);
                fail_count++;
            end
            if (got.any_moved !== want.any_moved)
            begin
                $display("%0t: ch %0d any_moved expected %0b actual %0b",
                         $time, want.out_channel, want.any_moved, got.any_moved);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: ch %0d last expected %0b actual %0b",
                         $time, want.out_channel, want.last, got.last);
                fail_count++;
            end
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    logic               item_valid;
    logic               item_ready;
    lcf_pkg::in_item_t  item;

    logic               result_valid;
    logic               result_ready = 1'b0;
    lcf_pkg::out_item_t result;

    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lcf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data;

    fade_scoreboard sb;

    // Sender burst bookkeeping: requests left in the current burst.
    int burst_left;

    // Receiver stall pattern: remaining stall cycles, the chance of a new
    // stall in percent, and a cycle count that moves between stall profiles.
    int          stall_left = 0;
    int          stall_pct  = 0;
    int unsigned cycle_count = 0;

    led_channel_fader #(
        .NUM_CHANNELS(NCH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Every process below samples the block at the rising edge, before any
    // nonblocking update of that edge lands, so the handshakes it sees are
    // the ones that the edge actually completes.

    // Watchdog. A stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** led_channel_fader: FAILED **");
            $finish;
        end
    end

    // Receiver. It stalls in runs of random length; how often depends on a
    // profile that the cycle count moves between, from never stalling to
    // stalling most of the time.
    always @(posedge clk)
    begin
        if ((cycle_count % 700) == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 15;
                2: stall_pct <= 40;
                default: stall_pct <= 75;
            endcase
        end
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
                stall_left <= $urandom_range(1, 7);
        end
    end

    // Every report the block hands over is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    function automatic lcf_pkg::in_item_t make_request(logic [1:0] cmd, logic [2:0] ch,
                                                       logic [7:0] lvl);
        lcf_pkg::in_item_t r;
        r.cmd     = cmd;
        r.channel = ch;
        r.level   = lvl;
        return r;
    endfunction

    // Levels favor the two ends of the range, where the fades saturate or wrap.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Valid is
    // left high on return so that a following request goes out back to back.
    task automatic send_request(input lcf_pkg::in_item_t req);
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_request(req);
    endtask

    // Send one request as part of a burst. When the burst runs out the
    // sender drops valid for a random gap and starts a new burst.
    task automatic issue(input lcf_pkg::in_item_t req);
        send_request(req);
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Stop sending and wait for every owed report, then for the block to
    // finish any request that gives no report.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both fade registers back to back. Only called once drained.
    task automatic configure(input logic [7:0] step, input logic mode);
        cfg_index <= lcf_pkg::CFG_STEP_SIZE;
        cfg_data  <= step;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(lcf_pkg::CFG_STEP_SIZE, step);
        cfg_index <= lcf_pkg::CFG_FADE_MODE;
        cfg_data  <= {7'd0, mode};
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(lcf_pkg::CFG_FADE_MODE, {7'd0, mode});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         sent;
        int         roll;
        logic [7:0] step;
        logic       mode;

        sb         = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 4;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset register values first. A tick on
        // the cleared state moves nothing. Channel 0 then climbs toward 255,
        // channel 7 falls from 255, channel 3 sits on its target, and the
        // unused command code must give nothing.
        issue(make_request(lcf_pkg::CMD_TICK, 3'd5, 8'hA5));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd0, 8'd255));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd7, 8'd255));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd3, 8'd128));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd3, 8'd128));
        issue(make_request(lcf_pkg::CMD_UNUSED, 3'd5, 8'hAA));
        issue(make_request(lcf_pkg::CMD_TICK, 3'd0, 8'd0));
        issue(make_request(lcf_pkg::CMD_TICK, 3'd7, 8'd255));

        // A zero step: a channel above its target must stay put and must not
        // raise any_moved.
        drain();
        configure(8'd0, 1'b0);
        issue(make_request(lcf_pkg::CMD_TICK, 3'd2, 8'd0));

        // The largest step, where the nine-bit sum decides between a full
        // step and a single count.
        drain();
        configure(8'd255, 1'b0);
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd1, 8'd0));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd1, 8'd255));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd4, 8'd200));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd5, 8'd10));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd5, 8'd250));
        issue(make_request(lcf_pkg::CMD_TICK, 3'd0, 8'd0));

        // Flashy fade: doubling above the target, a doubling that wraps
        // below it, and a channel below its target that jumps straight up.
        drain();
        configure(8'd255, 1'b1);
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd1, 8'd200));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd1, 8'd100));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd2, 8'd130));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd2, 8'd10));
        issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'd6, 8'd5));
        issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'd6, 8'd250));
        issue(make_request(lcf_pkg::CMD_TICK, 3'd0, 8'd0));
        issue(make_request(lcf_pkg::CMD_TICK, 3'd0, 8'd0));
        issue(make_request(lcf_pkg::CMD_UNUSED, 3'd2, 8'h55));

        // Random part: six phases, each with its own register setting, the
        // extreme steps among them. Within a phase, set requests scatter
        // levels and short runs of ticks let the fades play out.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin step = 8'd1;   mode = 1'b0; end
                1: begin step = 8'd0;   mode = 1'b0; end
                2: begin step = 8'd255; mode = 1'b0; end
                3: begin step = 8'($urandom); mode = 1'b1; end
                4: begin step = 8'($urandom_range(2, 40)); mode = 1'b0; end
                default: begin step = pick_level(); mode = 1'($urandom); end
            endcase
            drain();
            configure(step, mode);

            sent = 0;
            while (sent < 31)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 38)
                begin
                    issue(make_request(lcf_pkg::CMD_SET_TARGET, 3'($urandom),
                                       pick_level()));
                    sent++;
                end
                else if (roll < 62)
                begin
                    issue(make_request(lcf_pkg::CMD_SET_BRIGHT, 3'($urandom),
                                       pick_level()));
                    sent++;
                end
                else if (roll < 95)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        issue(make_request(lcf_pkg::CMD_TICK, 3'($urandom), 8'($urandom)));
                        sent++;
                    end
                end
                else
                begin
                    // The unused code is ignored by the block and is not counted.
                    issue(make_request(lcf_pkg::CMD_UNUSED, 3'($urandom), 8'($urandom)));
                end

                // Midway through a phase the sender sometimes holds off until
                // the block has handed over every report it owes.
                if (sent == 15 && $urandom_range(0, 1) == 0)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
            end
        end

        drain();
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("** led_channel_fader: PASSED **");
        else
            $display("** led_channel_fader: FAILED **");
        $finish;
    end

endmodule
